/* rtl/gls_pkg.sv */
// Shared types and constants for the grid line-of-sight block.
// Used by gls_ctrl, gls_datapath and grid_line_of_sight; no dependencies.
package gls_pkg;

  localparam int COORD_W = 9;

  typedef logic [COORD_W-1:0] coord_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_WALK,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic wr;     // store one tile bit from the input ports
    logic load;   // capture query endpoints (ordered so x grows)
    logic setup;  // compute deltas and divisor, clear accumulators
    logic step;   // advance one cell and read the map there
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic short_line;  // divisor below two: no intermediate cells
    logic last_step;   // the step issued now is the final one
    logic blocked;     // cell read on the previous step is opaque or off the map
  } dp_status_t;

endpackage

/* rtl/grid_line_of_sight.sv */
// Top level of the grid line-of-sight block: joins controller and datapath.
// Depends on gls_pkg, gls_ctrl and gls_datapath.
//
// Usage: in_valid/in_ready carry one transaction per item. operation selects
// a tile write (tile_x, tile_y, see_through) or a query (start_x, start_y,
// end_x, end_y). A write produces no result. A query
// produces exactly one out_valid/out_ready transaction carrying visible.
// A query walks one map cell per cycle, reading the map in the stepping
// loop; an opaque cell ends the walk early. One query is in flight at a
// time; in_ready is high only while the controller is idle.
// The map is a memory of MAP_DIM*MAP_DIM bits with no reset: software loads
// the tiles before querying. Reset returns the controller to idle and
// empties the output register.
// When the receiver stalls, the result waits in the output register and the
// block keeps accepting writes and a new query; that query only completes
// once the output register has been taken.
module grid_line_of_sight import gls_pkg::*; #(
  parameter int MAP_DIM = 512
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   operation,
  input  coord_t tile_x,
  input  coord_t tile_y,
  input  logic   see_through,
  input  coord_t start_x,
  input  coord_t start_y,
  input  coord_t end_x,
  input  coord_t end_y,
  output logic   out_valid,
  input  logic   out_ready,
  output logic   visible
);

  dp_cmd_t    cmd;
  dp_status_t status;

  gls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .operation (operation),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible),
    .cmd       (cmd),
    .status    (status)
  );

  gls_datapath #(
    .MAP_DIM (MAP_DIM)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .tile_x      (tile_x),
    .tile_y      (tile_y),
    .see_through (see_through),
    .start_x     (start_x),
    .start_y     (start_y),
    .end_x       (end_x),
    .end_y       (end_y)
  );

  // accepted query always goes to setup next
  a_query_setup: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && operation == OP_QUERY) |=> (cmd.setup && !in_ready))
    else $error("query transaction not followed by setup");

  // a blocked report must stem from a read issued the cycle before
  a_blocked_src: assert property (@(posedge clk) disable iff (rst)
    status.blocked |-> $past(cmd.step))
    else $error("blocked status without a preceding map read");

  // no further step after the final one
  a_last_step: assert property (@(posedge clk) disable iff (rst)
    (cmd.step && status.last_step) |=> !cmd.step)
    else $error("stepper ran past the end cell");

  // stepping never overlaps the input handshake
  a_step_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> (!in_ready && !cmd.wr))
    else $error("map read while input side open");

endmodule

/* rtl/gls_datapath.sv */
// Datapath of the grid line-of-sight block: tile map memory, endpoint
// registers and the DDA stepper. Depends on gls_pkg.
module gls_datapath import gls_pkg::*; #(
  parameter int MAP_DIM = 512
) (
  input  logic       clk,
  input  logic       rst,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  input  coord_t     tile_x,
  input  coord_t     tile_y,
  input  logic       see_through,
  input  coord_t     start_x,
  input  coord_t     start_y,
  input  coord_t     end_x,
  input  coord_t     end_y
);

  localparam int CW        = $clog2(MAP_DIM);
  localparam int XW        = (CW > COORD_W) ? CW : COORD_W;
  localparam int MEM_DEPTH = 1 << (2 * CW);

  logic sight_map [MEM_DEPTH];

  coord_t cx, cy, ex, ey;
  coord_t dx, div, cnt, ax;
  logic signed [COORD_W:0] dy, ay;
  logic rd_valid, rd_bit;

  // setup terms
  logic                    swap;
  coord_t                  dx_c, ady_c, div_c;
  logic signed [COORD_W:0] dy_c;

  // step terms
  logic [COORD_W:0]          ax_sum;
  logic [COORD_W:0]          ax_tmp;
  logic signed [COORD_W+1:0] ay_sum, ay_tmp, div_s;
  coord_t                    ax_next, nx, ny;
  logic signed [COORD_W:0]   ay_next;

  logic [XW-1:0]     nx_e, ny_e, wx_e, wy_e;
  logic [2*CW-1:0]   raddr, waddr;
  logic              wr_ok, cur_oob;

  assign swap = end_x < start_x;

  always_comb begin
    dx_c  = ex - cx;
    dy_c  = $signed({1'b0, ey}) - $signed({1'b0, cy});
    ady_c = dy_c[COORD_W] ? coord_t'(-dy_c) : coord_t'(dy_c);
    div_c = (dx_c > ady_c) ? dx_c : ady_c;
  end

  always_comb begin
    ax_sum = {1'b0, ax} + {1'b0, dx};
    ax_tmp = ax_sum - {1'b0, div};
    if (ax_sum >= {1'b0, div}) begin
      ax_next = ax_tmp[COORD_W-1:0];
      nx      = cx + coord_t'(1);
    end else begin
      ax_next = ax_sum[COORD_W-1:0];
      nx      = cx;
    end

    div_s  = $signed({2'b00, div});
    ay_sum = $signed({ay[COORD_W], ay}) + $signed({dy[COORD_W], dy});
    ay_tmp = ay_sum;
    ny     = cy;
    if (ay_sum >= div_s) begin
      ay_tmp = ay_sum - div_s;
      ny     = cy + coord_t'(1);
    end else if (ay_sum < 0) begin
      ay_tmp = ay_sum + div_s;
      ny     = cy - coord_t'(1);
    end
    ay_next = ay_tmp[COORD_W:0];
  end

  // map address is {row, column} at CW bits each
  always_comb begin
    nx_e  = XW'(nx);
    ny_e  = XW'(ny);
    wx_e  = XW'(tile_x);
    wy_e  = XW'(tile_y);
    raddr = {ny_e[CW-1:0], nx_e[CW-1:0]};
    waddr = {wy_e[CW-1:0], wx_e[CW-1:0]};
  end

  assign wr_ok   = (int'(tile_x) < MAP_DIM) && (int'(tile_y) < MAP_DIM);
  // cursor holds the coordinates of the cell whose bit sits in rd_bit
  assign cur_oob = (int'(cx) >= MAP_DIM) || (int'(cy) >= MAP_DIM);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx <= swap ? end_x   : start_x;
      cy <= swap ? end_y   : start_y;
      ex <= swap ? start_x : end_x;
      ey <= swap ? start_y : end_y;
    end else if (cmd.setup) begin
      dx  <= dx_c;
      dy  <= dy_c;
      div <= div_c;
      ax  <= '0;
      ay  <= '0;
      cnt <= coord_t'(1);
    end else if (cmd.step) begin
      cx  <= nx;
      cy  <= ny;
      ax  <= ax_next;
      ay  <= ay_next;
      cnt <= cnt + coord_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      sight_map[waddr] <= see_through;
    end
    if (cmd.step) begin
      rd_bit <= sight_map[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= cmd.step;
    end
  end

  assign status.blocked    = rd_valid && (!rd_bit || cur_oob);
  assign status.short_line = (div[COORD_W-1:1] == '0);
  assign status.last_step  = (({1'b0, cnt} + 10'd1) == {1'b0, div});

endmodule

/* rtl/gls_ctrl.sv */
// Controller of the grid line-of-sight block: sequencing state machine and
// the result output register. Depends on gls_pkg.
module gls_ctrl import gls_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       operation,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       visible,
  output dp_cmd_t    cmd,
  input  dp_status_t status
);

  state_t state, state_next;
  logic   res_bit, res_next;
  logic   load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    res_bit <= res_next;
    if (load_out) begin
      visible <= res_bit;
    end
  end

  always_comb begin
    state_next = state;
    res_next   = res_bit;
    load_out   = 1'b0;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (operation == OP_QUERY) begin
            cmd.load   = 1'b1;
            state_next = ST_SETUP;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.blocked) begin
          res_next   = 1'b0;
          state_next = ST_DONE;
        end else if (status.short_line) begin
          res_next   = 1'b1;
          state_next = ST_DONE;
        end else begin
          cmd.step = 1'b1;
          if (status.last_step) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // last read returns now
        res_next   = !status.blocked;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule
